// ----- hw/rtl/bbr_pkg.sv -----
// ============================================================================
// bbr_pkg: shared types and constants of the 3x3 RGB box blur
// Sizes of the history ring and job queue, the job and history-write
// structs, the back-end state type and the small arithmetic tables.
// ============================================================================
`default_nettype none

package bbr_pkg;

    // widest frame the line history supports
    localparam int MAX_WIDTH      = 1024;

    // field widths fixed by the interface
    localparam int CHAN_W         = 8;
    localparam int PIX_W          = 3 * CHAN_W;
    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 16;
    localparam int ROW_W          = FRAME_HEIGHT_W;

    // column index, effective width and pending-count widths
    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int PEND_W = $clog2(MAX_WIDTH + 2);

    // job queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // history ring: two rows plus three pixels plus room for the front to run ahead
    localparam int HIST_AW    = $clog2(2 * MAX_WIDTH + 3 + 4 * FIFO_DEPTH + 4);
    localparam int HIST_DEPTH = 1 << HIST_AW;

    // averaging arithmetic: sum of nine channels, times a 2^16 reciprocal
    localparam int SUM_W       = $clog2(9 * 255 + 1);
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;
    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = FRAME_WIDTH_W'(1024);
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = FRAME_HEIGHT_W'(768);

    // input item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // one pixel written into the history ring
    typedef struct packed {
        logic               en;
        logic [HIST_AW-1:0] addr;
        logic [PIX_W-1:0]   data;
    } bbr_hist_wr_t;

    // one result to compute: center address and which neighbors are in frame
    typedef struct packed {
        logic [HIST_AW-1:0] base;
        logic               up_ok;
        logic               down_ok;
        logic               left_ok;
        logic               right_ok;
        logic               frame_end;
    } bbr_job_t;

    // back-end sequencer
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_LAST,
        BK_MUL,
        BK_HOLD
    } bbr_back_state_t;

    // width register to effective width: 0 acts as 1, clamp at MAX_WIDTH
    function automatic logic [WID_W-1:0] eff_width(input logic [FRAME_WIDTH_W-1:0] fw);
        logic [WID_W-1:0] w;
        if (fw == '0) begin
            w = WID_W'(1);
        end else if (32'(fw) > MAX_WIDTH) begin
            w = WID_W'(MAX_WIDTH);
        end else begin
            w = WID_W'(fw);
        end
        return w;
    endfunction

    // height register to effective height: 0 acts as 1
    function automatic logic [ROW_W-1:0] eff_height(input logic [FRAME_HEIGHT_W-1:0] fh);
        return (fh == '0) ? ROW_W'(1) : fh;
    endfunction

    // number of in-frame neighbors, 1..9
    function automatic logic [3:0] nbr_count(input logic up, input logic down,
                                             input logic left, input logic right);
        logic [3:0] rows;
        logic [3:0] cols;
        rows = 4'd1 + {3'b0, up} + {3'b0, down};
        cols = 4'd1 + {3'b0, left} + {3'b0, right};
        return 4'(rows * cols);
    endfunction

    // ceil(2^16 / n); exact floor division for sums up to 9*255
    function automatic logic [RECIP_W-1:0] recip(input logic [3:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            4'd2:    r = RECIP_W'(32768);
            4'd3:    r = RECIP_W'(21846);
            4'd4:    r = RECIP_W'(16384);
            4'd5:    r = RECIP_W'(13108);
            4'd6:    r = RECIP_W'(10923);
            4'd7:    r = RECIP_W'(9363);
            4'd8:    r = RECIP_W'(8192);
            4'd9:    r = RECIP_W'(7282);
            default: r = RECIP_W'(65536);
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bbr_stream_if.sv -----
// ============================================================================
// bbr_stream_if: valid/ready channels of the box blur
// bbr_pix_if carries input items, bbr_res_if carries blurred results.
// ============================================================================
`default_nettype none

interface bbr_pix_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [bbr_pkg::CHAN_W-1:0]  in_red;
    logic [bbr_pkg::CHAN_W-1:0]  in_green;
    logic [bbr_pkg::CHAN_W-1:0]  in_blue;

    modport source (output valid, kind, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, kind, in_red, in_green, in_blue, output ready);
endinterface

interface bbr_res_if;
    logic                        valid;
    logic                        ready;
    logic [bbr_pkg::CHAN_W-1:0]  out_red;
    logic [bbr_pkg::CHAN_W-1:0]  out_green;
    logic [bbr_pkg::CHAN_W-1:0]  out_blue;
    logic                        frame_end;

    modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bbr_front.sv -----
// ============================================================================
// bbr_front: input side of the box blur
// Takes pixels and drains, writes pixels into the history ring, tracks the
// input and output raster positions and the pending count, and queues one
// job per result with its center address and frame-edge flags.
// ============================================================================
`default_nettype none

module bbr_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    bbr_pix_if.sink                           pixel,
    input  wire logic [bbr_pkg::WID_W-1:0]    w_eff,
    input  wire logic [bbr_pkg::ROW_W-1:0]    h_eff,
    input  wire logic                         restart,
    input  wire logic                         fifo_full,
    output bbr_pkg::bbr_job_t                 job,
    output logic                              job_push,
    output bbr_pkg::bbr_hist_wr_t             hist_wr
);

    logic [bbr_pkg::COL_W-1:0]   in_col_reg,  in_col_next;
    logic [bbr_pkg::ROW_W-1:0]   in_row_reg,  in_row_next;
    logic [bbr_pkg::COL_W-1:0]   out_col_reg, out_col_next;
    logic [bbr_pkg::ROW_W-1:0]   out_row_reg, out_row_next;
    logic [bbr_pkg::PEND_W-1:0]  pending_reg, pending_next;
    logic [bbr_pkg::HIST_AW-1:0] wr_ptr_reg,  wr_ptr_next;

    logic accept;
    logic is_drain;
    logic emit;
    logic in_col_last;
    logic in_row_last;
    logic out_col_last;
    logic out_row_last;

    // accept whenever a job slot is free
    assign pixel.ready = !fifo_full;
    assign accept      = pixel.valid && pixel.ready;
    assign is_drain    = (pixel.kind == bbr_pkg::KIND_DRAIN);

    // raster edges
    assign in_col_last  = (bbr_pkg::WID_W'(in_col_reg) + bbr_pkg::WID_W'(1)) == w_eff;
    assign in_row_last  = (17'(in_row_reg) + 17'(1)) == 17'(h_eff);
    assign out_col_last = (bbr_pkg::WID_W'(out_col_reg) + bbr_pkg::WID_W'(1)) == w_eff;
    assign out_row_last = (17'(out_row_reg) + 17'(1)) == 17'(h_eff);

    // classify: a pixel answers once the lag is full, a drain only at frame start
    always_comb
    begin
        if (is_drain) begin
            emit = (in_col_reg == '0) && (in_row_reg == '0) && (pending_reg != '0);
        end else begin
            emit = 32'(pending_reg) > 32'(w_eff);
        end
    end

    // job for the pixel at the output position
    always_comb
    begin
        job.base      = wr_ptr_reg - bbr_pkg::HIST_AW'(pending_reg);
        job.up_ok     = (out_row_reg != '0);
        job.down_ok   = !out_row_last;
        job.left_ok   = (out_col_reg != '0);
        job.right_ok  = !out_col_last;
        job.frame_end = out_row_last && out_col_last;
        job_push      = accept && emit;
    end

    // history write
    always_comb
    begin
        hist_wr.en   = accept && !is_drain;
        hist_wr.addr = wr_ptr_reg;
        hist_wr.data = {pixel.in_red, pixel.in_green, pixel.in_blue};
    end

    // position and pending bookkeeping
    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pending_next = pending_reg;
        wr_ptr_next  = wr_ptr_reg;
        if (restart) begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            pending_next = '0;
            wr_ptr_next  = '0;
        end else if (accept) begin
            if (!is_drain) begin
                wr_ptr_next = wr_ptr_reg + bbr_pkg::HIST_AW'(1);
                if (in_col_last) begin
                    in_col_next = '0;
                    in_row_next = in_row_last ? '0 : in_row_reg + bbr_pkg::ROW_W'(1);
                end else begin
                    in_col_next = in_col_reg + bbr_pkg::COL_W'(1);
                end
                if (!emit) begin
                    pending_next = pending_reg + bbr_pkg::PEND_W'(1);
                end
            end else if (emit) begin
                pending_next = pending_reg - bbr_pkg::PEND_W'(1);
            end
            if (emit) begin
                if (out_col_last) begin
                    out_col_next = '0;
                    out_row_next = out_row_last ? '0 : out_row_reg + bbr_pkg::ROW_W'(1);
                end else begin
                    out_col_next = out_col_reg + bbr_pkg::COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pending_reg <= '0;
            wr_ptr_reg  <= '0;
        end else begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            pending_reg <= pending_next;
            wr_ptr_reg  <= wr_ptr_next;
        end
    end

    // lag never exceeds one row plus one pixel
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pending_reg) <= 32'(w_eff) + 32'd1)
        else $error("pending count above lag limit");

    // a result is only queued when a slot exists
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !fifo_full)
        else $error("job pushed into full queue");

endmodule

`default_nettype wire

// ----- hw/rtl/bbr_job_fifo.sv -----
// ============================================================================
// bbr_job_fifo: short job queue between front and back
// Register-based FIFO of result jobs; lets the front keep accepting while
// the back works on an earlier result.
// ============================================================================
`default_nettype none

module bbr_job_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire bbr_pkg::bbr_job_t  push_job,
    input  wire logic               pop,
    output bbr_pkg::bbr_job_t       pop_job,
    output logic                    full,
    output logic                    empty
);

    bbr_pkg::bbr_job_t                slot_q [bbr_pkg::FIFO_DEPTH];
    logic [bbr_pkg::FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [bbr_pkg::FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [bbr_pkg::FIFO_CNT_W-1:0]   count_reg,  count_next;

    assign full    = (count_reg == bbr_pkg::FIFO_CNT_W'(bbr_pkg::FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = slot_q[rd_ptr_reg];

    // pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + bbr_pkg::FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + bbr_pkg::FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + bbr_pkg::FIFO_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - bbr_pkg::FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_q[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bbr_back.sv -----
// ============================================================================
// bbr_back: result side of the box blur
// Holds the pixel history ring, reads the nine neighbors of each queued job
// through its single read port, sums the in-frame ones, divides by the
// neighbor count with a reciprocal multiply and drives the result register.
// ============================================================================
`default_nettype none

module bbr_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire bbr_pkg::bbr_hist_wr_t        hist_wr,
    input  wire logic [bbr_pkg::WID_W-1:0]    w_eff,
    input  wire bbr_pkg::bbr_job_t            job,
    input  wire logic                         fifo_empty,
    output logic                              fifo_pop,
    bbr_res_if.source                         result
);

    bbr_pkg::bbr_back_state_t         state_reg, state_next;

    logic [bbr_pkg::PIX_W-1:0]        hist_mem [bbr_pkg::HIST_DEPTH];
    logic [bbr_pkg::PIX_W-1:0]        rd_data_reg;

    bbr_pkg::bbr_job_t                job_reg;
    logic [bbr_pkg::HIST_AW-1:0]      row_up_reg;
    logic [bbr_pkg::HIST_AW-1:0]      row_dn_reg;
    logic [1:0]                       r_idx_reg, r_idx_next;
    logic [1:0]                       c_idx_reg, c_idx_next;
    logic                             acc_en_reg;

    logic [bbr_pkg::SUM_W-1:0]        sum_r_reg, sum_g_reg, sum_b_reg;
    logic [bbr_pkg::PROD_W-1:0]       prod_r_reg, prod_g_reg, prod_b_reg;
    logic [bbr_pkg::RECIP_W-1:0]      recip_val;

    logic                             res_valid_reg;
    logic [bbr_pkg::CHAN_W-1:0]       out_red_reg, out_green_reg, out_blue_reg;
    logic                             out_frame_end_reg;

    logic                             rd_en;
    logic                             mul_en;
    logic                             load_out;
    logic                             last_step;
    logic [bbr_pkg::HIST_AW-1:0]      row_addr;
    logic [bbr_pkg::HIST_AW-1:0]      rd_addr;
    logic                             row_ok;
    logic                             nbr_ok;

    assign last_step = (r_idx_reg == 2'd2) && (c_idx_reg == 2'd2);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bbr_pkg::BK_IDLE: if (!fifo_empty) state_next = bbr_pkg::BK_READ;
            bbr_pkg::BK_READ: if (last_step)   state_next = bbr_pkg::BK_LAST;
            bbr_pkg::BK_LAST:                  state_next = bbr_pkg::BK_MUL;
            bbr_pkg::BK_MUL:                   state_next = bbr_pkg::BK_HOLD;
            bbr_pkg::BK_HOLD: if (!res_valid_reg || result.ready)
                                               state_next = bbr_pkg::BK_IDLE;
            default:                           state_next = bbr_pkg::BK_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        fifo_pop = 1'b0;
        rd_en    = 1'b0;
        mul_en   = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            bbr_pkg::BK_IDLE: fifo_pop = !fifo_empty;
            bbr_pkg::BK_READ: rd_en    = 1'b1;
            bbr_pkg::BK_LAST: ;
            bbr_pkg::BK_MUL:  mul_en   = 1'b1;
            bbr_pkg::BK_HOLD: load_out = !res_valid_reg || result.ready;
            default: ;
        endcase
    end

    // neighbor walk: row above, center row, row below; left, center, right
    always_comb
    begin
        case (r_idx_reg)
            2'd0:    begin row_addr = row_up_reg;   row_ok = job_reg.up_ok;   end
            2'd2:    begin row_addr = row_dn_reg;   row_ok = job_reg.down_ok; end
            default: begin row_addr = job_reg.base; row_ok = 1'b1;            end
        endcase
        case (c_idx_reg)
            2'd0:    begin
                rd_addr = row_addr - bbr_pkg::HIST_AW'(1);
                nbr_ok  = row_ok && job_reg.left_ok;
            end
            2'd2:    begin
                rd_addr = row_addr + bbr_pkg::HIST_AW'(1);
                nbr_ok  = row_ok && job_reg.right_ok;
            end
            default: begin
                rd_addr = row_addr;
                nbr_ok  = row_ok;
            end
        endcase
    end

    // walk counters
    always_comb
    begin
        r_idx_next = r_idx_reg;
        c_idx_next = c_idx_reg;
        if (fifo_pop) begin
            r_idx_next = '0;
            c_idx_next = '0;
        end else if (rd_en && !last_step) begin
            if (c_idx_reg == 2'd2) begin
                c_idx_next = '0;
                r_idx_next = r_idx_reg + 2'd1;
            end else begin
                c_idx_next = c_idx_reg + 2'd1;
            end
        end
    end

    assign recip_val = bbr_pkg::recip(bbr_pkg::nbr_count(job_reg.up_ok, job_reg.down_ok,
                                                         job_reg.left_ok, job_reg.right_ok));

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= bbr_pkg::BK_IDLE;
            r_idx_reg     <= '0;
            c_idx_reg     <= '0;
            acc_en_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            r_idx_reg  <= r_idx_next;
            c_idx_reg  <= c_idx_next;
            acc_en_reg <= rd_en && nbr_ok;
            if (load_out) begin
                res_valid_reg <= 1'b1;
            end else if (result.ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // history ring: one write port from the front, one registered read port
    always_ff @(posedge clk)
    begin
        if (hist_wr.en) begin
            hist_mem[hist_wr.addr] <= hist_wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= hist_mem[rd_addr];
        end
    end

    // job capture, accumulation, reciprocal multiply, result load
    always_ff @(posedge clk)
    begin
        if (fifo_pop) begin
            job_reg    <= job;
            row_up_reg <= job.base - bbr_pkg::HIST_AW'(w_eff);
            row_dn_reg <= job.base + bbr_pkg::HIST_AW'(w_eff);
            sum_r_reg  <= '0;
            sum_g_reg  <= '0;
            sum_b_reg  <= '0;
        end else if (acc_en_reg) begin
            sum_r_reg <= sum_r_reg + bbr_pkg::SUM_W'(rd_data_reg[2*bbr_pkg::CHAN_W +: bbr_pkg::CHAN_W]);
            sum_g_reg <= sum_g_reg + bbr_pkg::SUM_W'(rd_data_reg[bbr_pkg::CHAN_W +: bbr_pkg::CHAN_W]);
            sum_b_reg <= sum_b_reg + bbr_pkg::SUM_W'(rd_data_reg[0 +: bbr_pkg::CHAN_W]);
        end
        if (mul_en) begin
            prod_r_reg <= bbr_pkg::PROD_W'(sum_r_reg) * bbr_pkg::PROD_W'(recip_val);
            prod_g_reg <= bbr_pkg::PROD_W'(sum_g_reg) * bbr_pkg::PROD_W'(recip_val);
            prod_b_reg <= bbr_pkg::PROD_W'(sum_b_reg) * bbr_pkg::PROD_W'(recip_val);
        end
        if (load_out) begin
            out_red_reg       <= prod_r_reg[bbr_pkg::RECIP_SHIFT +: bbr_pkg::CHAN_W];
            out_green_reg     <= prod_g_reg[bbr_pkg::RECIP_SHIFT +: bbr_pkg::CHAN_W];
            out_blue_reg      <= prod_b_reg[bbr_pkg::RECIP_SHIFT +: bbr_pkg::CHAN_W];
            out_frame_end_reg <= job_reg.frame_end;
        end
    end

    assign result.valid     = res_valid_reg;
    assign result.out_red   = out_red_reg;
    assign result.out_green = out_green_reg;
    assign result.out_blue  = out_blue_reg;
    assign result.frame_end = out_frame_end_reg;

    // read data is only summed right after a neighbor read
    a_acc_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        acc_en_reg |-> ($past(state_reg) == bbr_pkg::BK_READ))
        else $error("accumulate without a preceding neighbor read");

    // all neighbor data summed before the multiply samples the sums
    a_mul_after_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bbr_pkg::BK_MUL) |-> !acc_en_reg)
        else $error("multiply while neighbor sum still open");

    // a held result is not dropped while the sink stalls
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !result.ready) |=> res_valid_reg)
        else $error("stalled result lost");

endmodule

`default_nettype wire

// ----- hw/rtl/box_blur_3x3_rgb.sv -----
// ============================================================================
// box_blur_3x3_rgb: streaming 3x3 box blur of RGB pixels
// Per-channel truncated mean over the in-frame 3x3 neighborhood, one row
// plus one pixel behind the input; drain items flush the tail of a frame.
//
//   channel   dir   handshake          payload
//   pixel     in    valid/ready        kind, in_red, in_green, in_blue
//   result    out   valid/ready        out_red, out_green, out_blue, frame_end
//   apb       in    psel/penable       0x0 frame_width, 0x4 frame_height
//
// A pixel that yields no result is taken while the job queue has room. The
// back end works on one result at a time: one job pop, nine neighbor reads
// on the single history read port, a step for the last read data, one
// reciprocal multiply and one load of the result register.
// Reset clears positions and control only; the history ring holds no reset
// value and needs no clearing pass. A register write restarts the stream.
// ============================================================================
`default_nettype none

module box_blur_3x3_rgb (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    bbr_pix_if.sink                            pixel,
    bbr_res_if.source                          result,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bbr_pkg::APB_AW-1:0]    paddr,
    input  wire logic [bbr_pkg::APB_DW-1:0]    pwdata,
    output logic [bbr_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);

    logic [bbr_pkg::FRAME_WIDTH_W-1:0]  frame_width_reg;
    logic [bbr_pkg::FRAME_HEIGHT_W-1:0] frame_height_reg;
    logic [bbr_pkg::WID_W-1:0]          w_eff;
    logic [bbr_pkg::ROW_W-1:0]          h_eff;
    logic                               cfg_wr;

    bbr_pkg::bbr_job_t                  push_job;
    bbr_pkg::bbr_job_t                  pop_job;
    bbr_pkg::bbr_hist_wr_t              hist_wr;
    logic                               job_push;
    logic                               fifo_pop;
    logic                               fifo_full;
    logic                               fifo_empty;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            frame_width_reg  <= bbr_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= bbr_pkg::FRAME_HEIGHT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                bbr_pkg::REG_FRAME_WIDTH:
                    frame_width_reg  <= pwdata[bbr_pkg::FRAME_WIDTH_W-1:0];
                bbr_pkg::REG_FRAME_HEIGHT:
                    frame_height_reg <= pwdata[bbr_pkg::FRAME_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (paddr[2])
            bbr_pkg::REG_FRAME_WIDTH:  prdata = bbr_pkg::APB_DW'(frame_width_reg);
            bbr_pkg::REG_FRAME_HEIGHT: prdata = bbr_pkg::APB_DW'(frame_height_reg);
            default:                   prdata = '0;
        endcase
    end

    assign w_eff = bbr_pkg::eff_width(frame_width_reg);
    assign h_eff = bbr_pkg::eff_height(frame_height_reg);

    bbr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel),
        .w_eff     (w_eff),
        .h_eff     (h_eff),
        .restart   (cfg_wr),
        .fifo_full (fifo_full),
        .job       (push_job),
        .job_push  (job_push),
        .hist_wr   (hist_wr)
    );

    bbr_job_fifo u_job_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .pop      (fifo_pop),
        .pop_job  (pop_job),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    bbr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .hist_wr    (hist_wr),
        .w_eff      (w_eff),
        .job        (pop_job),
        .fifo_empty (fifo_empty),
        .fifo_pop   (fifo_pop),
        .result     (result)
    );

endmodule

`default_nettype wire

// ----- bench/blur_result_check.sv -----
// ============================================================================
// blur_result_check: result predictor and comparator for the 3x3 RGB blur
// Watches the pixel, result and register ports, keeps its own pixel history
// and stream positions, predicts each blurred pixel and compares it field
// by field with what the block returns.
// ============================================================================
module blur_result_check
    import bbr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    bbr_pix_if                   pixel,
    bbr_res_if                   result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output int                   mismatches,
    output int                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // two rows plus three pixels of history
    localparam int RING_LEN = 2 * MAX_WIDTH + 3;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              frame_end;
    } blurred_px_t;

    logic [PIX_W-1:0]          pix_ring [RING_LEN];
    logic [FRAME_WIDTH_W-1:0]  width_reg;
    logic [FRAME_HEIGHT_W-1:0] height_reg;
    int unsigned               in_col;
    int unsigned               in_row;
    int unsigned               out_col;
    int unsigned               out_row;
    int unsigned               unanswered;
    int unsigned               ring_wr;
    blurred_px_t               blurred_expected [$];

    // register value to the width actually used
    function automatic int unsigned act_width();
        if (width_reg == '0)
            return 1;
        else if (int'(width_reg) > MAX_WIDTH)
            return MAX_WIDTH;
        else
            return int'(width_reg);
    endfunction

    function automatic int unsigned act_height();
        return (height_reg == '0) ? 1 : int'(height_reg);
    endfunction

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // positions and history pointer back to the start of a stream
    task automatic restart_stream();
        in_col     = 0;
        in_row     = 0;
        out_col    = 0;
        out_row    = 0;
        unanswered = 0;
        ring_wr    = 0;
    endtask

    // mean of the in-frame neighbors of the oldest unanswered pixel
    task automatic predict_mean();
        int unsigned      w;
        int unsigned      h;
        int unsigned      centre;
        int unsigned      cnt;
        int unsigned      idx;
        int unsigned      sum_r;
        int unsigned      sum_g;
        int unsigned      sum_b;
        int               rr;
        int               cc;
        logic [PIX_W-1:0] p;
        blurred_px_t      px;
        w      = act_width();
        h      = act_height();
        centre = (ring_wr + RING_LEN - unanswered) % RING_LEN;
        cnt    = 0;
        sum_r  = 0;
        sum_g  = 0;
        sum_b  = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                rr = int'(out_row) + dr;
                cc = int'(out_col) + dc;
                if (rr >= 0 && rr < int'(h) && cc >= 0 && cc < int'(w)) begin
                    idx   = unsigned'((int'(centre) + RING_LEN + dr * int'(w) + dc) % RING_LEN);
                    p     = pix_ring[idx];
                    sum_r += p[2*CHAN_W +: CHAN_W];
                    sum_g += p[CHAN_W +: CHAN_W];
                    sum_b += p[0 +: CHAN_W];
                    cnt++;
                end
            end
        end
        px.red       = CHAN_W'(sum_r / cnt);
        px.green     = CHAN_W'(sum_g / cnt);
        px.blue      = CHAN_W'(sum_b / cnt);
        px.frame_end = (out_row == h - 1) && (out_col == w - 1);
        blurred_expected.push_back(px);
        // advance the result position
        unanswered--;
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
            if (out_row >= h)
                out_row = 0;
        end
    endtask

    // one accepted input item
    task automatic take_item(input logic kind, input logic [CHAN_W-1:0] r,
                             input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
        int unsigned w;
        int unsigned h;
        w = act_width();
        h = act_height();
        if (kind == KIND_DRAIN) begin
            // a drain only acts at a frame boundary with results owed
            if (in_col == 0 && in_row == 0 && unanswered > 0)
                predict_mean();
        end else begin
            pix_ring[ring_wr] = {r, g, b};
            ring_wr           = (ring_wr + 1) % RING_LEN;
            unanswered++;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
                if (in_row >= h)
                    in_row = 0;
            end
            if (unanswered > w + 1)
                predict_mean();
        end
    endtask

    task automatic check_result();
        blurred_px_t want;
        if (blurred_expected.size() == 0) begin
            report($sformatf("unexpected result r=%0d g=%0d b=%0d end=%0b",
                             result.out_red, result.out_green, result.out_blue,
                             result.frame_end));
        end else begin
            want = blurred_expected.pop_front();
            if (result.out_red !== want.red)
                report($sformatf("out_red %0d, want %0d", result.out_red, want.red));
            if (result.out_green !== want.green)
                report($sformatf("out_green %0d, want %0d", result.out_green, want.green));
            if (result.out_blue !== want.blue)
                report($sformatf("out_blue %0d, want %0d", result.out_blue, want.blue));
            if (result.frame_end !== want.frame_end)
                report($sformatf("frame_end %0b, want %0b", result.frame_end,
                                 want.frame_end));
        end
    endtask

    task automatic apply_write();
        logic [APB_AW-3:0] reg_index;
        reg_index = paddr[APB_AW-1:2];
        if (reg_index == REG_FRAME_WIDTH) begin
            width_reg = pwdata[FRAME_WIDTH_W-1:0];
            restart_stream();
        end else if (reg_index == REG_FRAME_HEIGHT) begin
            height_reg = pwdata[FRAME_HEIGHT_W-1:0];
            restart_stream();
        end
    endtask

    // sample every transfer at the clock edge
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            width_reg  = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            restart_stream();
            blurred_expected.delete();
            mismatches  = 0;
            outstanding = 0;
        end else begin
            if (result.valid && result.ready)
                check_result();
            if (psel && penable && pwrite && pready)
                apply_write();
            if (pixel.valid && pixel.ready)
                take_item(pixel.kind, pixel.in_red, pixel.in_green, pixel.in_blue);
            outstanding = blurred_expected.size();
        end
    end

endmodule

// ----- bench/tb.sv -----
// ============================================================================
// tb: top of the 3x3 RGB box blur bench
// Drives pixel and drain items under random gaps and result back-pressure,
// steps the frame size through its extremes over the register port, and
// reports the verdict from the result checker's mismatch count.
// ============================================================================
module tb;
    import bbr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NO_CAP        = 32'h7FFF_FFFF;
    localparam int SETTLE_CYCLES = 40;
    localparam int END_CYCLES    = 100;
    localparam int HOLD_CYCLES   = 300;
    localparam int ITEM_BUDGET   = 850;
    localparam logic [APB_AW-1:0] ADDR_FRAME_WIDTH  = APB_AW'(REG_FRAME_WIDTH) << 2;
    localparam logic [APB_AW-1:0] ADDR_FRAME_HEIGHT = APB_AW'(REG_FRAME_HEIGHT) << 2;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    int                mismatches;
    int                outstanding;

    // stimulus controls
    bit                calm;
    bit                no_gaps;
    bit                hold_req;
    bit                hold_done;
    int                items_sent;
    int                ew;
    int                eh;

    bbr_pix_if pixel_ch ();
    bbr_res_if result_ch ();

    box_blur_3x3_rgb dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixel   (pixel_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    blur_result_check result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel       (pixel_ch),
        .result      (result_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    // result receiver: random stall bursts, one long hold-off on request
    initial
    begin
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                result_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    // mostly random bytes, with the extremes weighted in
    function automatic logic [CHAN_W-1:0] rand_chan();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    // one item transfer, with an optional idle burst ahead of it
    task automatic send_item(input logic kind, input logic [CHAN_W-1:0] r,
                             input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
        if (!calm && !no_gaps && $urandom_range(0, 4) == 0)
        begin
            pixel_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        pixel_ch.valid    <= 1'b1;
        pixel_ch.kind     <= kind;
        pixel_ch.in_red   <= r;
        pixel_ch.in_green <= g;
        pixel_ch.in_blue  <= b;
        do @(posedge clk); while (!pixel_ch.ready);
        items_sent++;
    endtask

    task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] b);
        send_item(KIND_PIXEL, r, g, b);
    endtask

    // color bits of a drain are don't-care, so randomize them
    task automatic send_drain();
        send_item(KIND_DRAIN, rand_chan(), rand_chan(), rand_chan());
    endtask

    // stop offering and let every predicted result come back
    task automatic wait_idle();
        pixel_ch.valid <= 1'b0;
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input int data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= APB_DW'(data);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input int fw, input int fh);
        wait_idle();
        apb_write(ADDR_FRAME_WIDTH, fw);
        apb_write(ADDR_FRAME_HEIGHT, fh);
        ew = (fw == 0) ? 1 : ((fw > MAX_WIDTH) ? MAX_WIDTH : fw);
        eh = (fh == 0) ? 1 : fh;
    endtask

    // frames of random pixels with ignored mid-frame drains; between frames
    // a random share of the tail is drained, the last frame is drained fully
    task automatic run_phase(input int fw, input int fh, input int frames, input int cap,
                             input bit press);
        int size;
        int count;
        int k;
        int tail;
        configure(fw, fh);
        if (press)
            hold_req = 1'b1;
        tail = 0;
        size = ew * eh;
        for (int f = 0; f < frames; f++)
        begin
            count = (size < cap) ? size : cap;
            for (int i = 0; i < count; i++)
            begin
                if (i > 0 && $urandom_range(0, 9) == 0)
                    send_drain();
                send_pixel(rand_chan(), rand_chan(), rand_chan());
            end
            // frame left unfinished: the next register write discards it
            if (count < size)
                return;
            tail = (tail + size < ew + 1) ? tail + size : ew + 1;
            k    = (f == frames - 1) ? tail + $urandom_range(0, 2) : $urandom_range(0, tail);
            repeat (k) send_drain();
            tail = (k < tail) ? tail - k : 0;
        end
    endtask

    // stimulus and verdict
    initial
    begin
        int stop_at;
        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        pixel_ch.valid    <= 1'b0;
        pixel_ch.kind     <= KIND_PIXEL;
        pixel_ch.in_red   <= '0;
        pixel_ch.in_green <= '0;
        pixel_ch.in_blue  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset sizes: drain with nothing owed, then a drain in mid-frame
        send_drain();
        send_pixel(8'hFF, 8'h00, 8'hFF);
        send_drain();

        // 3x3 frame of alternating extremes, drained only in part
        configure(3, 3);
        for (int i = 0; i < 9; i++)
            send_pixel((i % 2 == 0) ? 8'hFF : 8'h00, (i % 2 == 0) ? 8'h00 : 8'hFF,
                       CHAN_W'(i * 31));
        repeat (2) send_drain();
        // all-white frame: full sums; the old tail leaves on the row lag
        repeat (9) send_pixel(8'hFF, 8'hFF, 8'hFF);
        repeat (5) send_drain();

        // register extremes: zero sizes, one pixel, tallest and widest frames
        run_phase(0, 0, 3, NO_CAP, 1'b0);
        run_phase(1, 1, 4, NO_CAP, 1'b0);
        run_phase(1024, 65535, 1, 30, 1'b0);
        run_phase(4, 65535, 1, 60, 1'b0);
        run_phase(2047, 1, 1, 40, 1'b0);

        // long result stall while pixels keep coming
        no_gaps = 1'b1;
        run_phase(2, 8, 3, NO_CAP, 1'b1);

        // random frame sizes, mostly small, up to the item budget
        stop_at = ITEM_BUDGET;
        while (items_sent < stop_at)
        begin
            calm    = (items_sent + 150 >= stop_at);
            no_gaps = ($urandom_range(0, 2) == 0);
            run_phase(($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8),
                      $urandom_range(0, 6), $urandom_range(1, 4), NO_CAP, 1'b0);
        end

        wait_idle();
        repeat (END_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/bbr_pkg.sv
hw/rtl/bbr_stream_if.sv
hw/rtl/bbr_front.sv
hw/rtl/bbr_job_fifo.sv
hw/rtl/bbr_back.sv
hw/rtl/box_blur_3x3_rgb.sv
bench/blur_result_check.sv
bench/tb.sv
